/* hdl/unicode_escape_to_utf8_assert.svh */
// Assertion macros used by the escape decoder top module.
`ifndef UNICODE_ESCAPE_TO_UTF8_ASSERT_SVH
`define UNICODE_ESCAPE_TO_UTF8_ASSERT_SVH

`ifndef SYNTHESIS
`define UCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder check failed");
`define UCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape decoder check failed");
`else
`define UCE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/uce_pkg.sv */
// Types, constants and helper functions of the escape decoder.
`timescale 1ns / 1ps
`default_nettype none
package uce_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_INVALID    = 3'd2,
        ST_BAD_DIGIT  = 3'd3,
        ST_RANGE      = 3'd4
    } t_status;

    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [7:0]  CH_BACKSLASH   = 8'h5C;
    localparam logic [7:0]  CH_LOWER_U     = 8'h75;
    localparam logic [7:0]  CH_UPPER_U     = 8'h55;
    localparam int          SHORT_DIGITS   = 4;
    localparam int          LONG_DIGITS    = 8;
    localparam logic [3:0]  POS_FIRST      = 4'd0;
    localparam logic [3:0]  POS_SECOND     = 4'd1;
    localparam logic [3:0]  LAST_POS_SHORT = 4'(SHORT_DIGITS + 1);
    localparam logic [3:0]  LAST_POS_LONG  = 4'(LONG_DIGITS + 1);

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [20:0] code_point;
        logic [3:0]  consumed;
    } t_step_res;

    // Returns {bad, value}; bad is set for any byte that is not a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = {1'b1, 4'd0};
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/uce_step.sv */
// Per-character escape parser: prefix check, hex accumulation and decision.
`timescale 1ns / 1ps
`default_nettype none
module uce_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_ch,
    input  wire logic              i_is_last,
    output uce_pkg::t_step_res     o_res
);

    logic [3:0]  r_pos, n_pos;
    logic        r_first_bs, n_first_bs;
    logic        r_long, n_long;
    logic        r_digit_bad, n_digit_bad;
    logic [31:0] r_acc, n_acc;
    logic        r_decided, n_decided;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_first_bs  <= 1'b0;
            r_long      <= 1'b0;
            r_digit_bad <= 1'b0;
            r_acc       <= '0;
            r_decided   <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_first_bs  <= n_first_bs;
            r_long      <= n_long;
            r_digit_bad <= n_digit_bad;
            r_acc       <= n_acc;
            r_decided   <= n_decided;
        end
    end

    always_comb begin
        logic [4:0] hex;
        logic       bad_prefix;
        logic [3:0] last_pos;
        hex         = uce_pkg::hex_digit(i_ch);
        bad_prefix  = !r_first_bs || (i_ch != uce_pkg::CH_LOWER_U && i_ch != uce_pkg::CH_UPPER_U);
        last_pos    = r_long ? uce_pkg::LAST_POS_LONG : uce_pkg::LAST_POS_SHORT;
        n_pos       = r_pos;
        n_first_bs  = r_first_bs;
        n_long      = r_long;
        n_digit_bad = r_digit_bad;
        n_acc       = r_acc;
        n_decided   = r_decided;
        o_res       = '{valid: 1'b0, status: uce_pkg::ST_OK, code_point: '0, consumed: '0};
        if (i_fire && !r_decided) begin
            case (r_pos)
                uce_pkg::POS_FIRST: begin
                    n_first_bs = (i_ch == uce_pkg::CH_BACKSLASH);
                    if (i_is_last) begin
                        o_res.valid  = 1'b1;
                        o_res.status = uce_pkg::ST_INCOMPLETE;
                    end
                end
                uce_pkg::POS_SECOND: begin
                    n_long = (i_ch == uce_pkg::CH_UPPER_U);
                    if (bad_prefix) begin
                        o_res.valid  = 1'b1;
                        o_res.status = uce_pkg::ST_INVALID;
                    end else if (i_is_last) begin
                        o_res.valid  = 1'b1;
                        o_res.status = uce_pkg::ST_INCOMPLETE;
                    end
                end
                default: begin
                    n_acc       = {r_acc[27:0], hex[3:0]};
                    n_digit_bad = r_digit_bad | hex[4];
                    if (r_pos == last_pos) begin
                        o_res.valid = 1'b1;
                        if (n_digit_bad) begin
                            o_res.status = uce_pkg::ST_BAD_DIGIT;
                        end else if (n_acc > {11'd0, uce_pkg::MAX_CODE_POINT}) begin
                            o_res.status = uce_pkg::ST_RANGE;
                        end else begin
                            o_res.status     = uce_pkg::ST_OK;
                            o_res.code_point = n_acc[20:0];
                            o_res.consumed   = last_pos + 4'd1;
                        end
                    end else if (i_is_last) begin
                        o_res.valid  = 1'b1;
                        o_res.status = uce_pkg::ST_INCOMPLETE;
                    end
                end
            endcase
            n_pos     = r_pos + 4'd1;
            n_decided = o_res.valid;
        end
        if (i_fire && i_is_last) begin
            n_pos       = '0;
            n_first_bs  = 1'b0;
            n_long      = 1'b0;
            n_digit_bad = 1'b0;
            n_acc       = '0;
            n_decided   = 1'b0;
        end
    end

endmodule
`default_nettype wire

/* hdl/uce_utf8_enc.sv */
// UTF-8 encoder for one decoded code point.
`timescale 1ns / 1ps
`default_nettype none
module uce_utf8_enc (
    input  wire logic        i_ok,
    input  wire logic [20:0] i_cp,
    output logic      [31:0] o_bytes,
    output logic      [2:0]  o_len
);

    always_comb begin
        o_bytes = '0;
        o_len   = '0;
        if (i_ok) begin
            if (i_cp < 21'h80) begin
                o_bytes = {25'd0, i_cp[6:0]};
                o_len   = 3'd1;
            end else if (i_cp < 21'h800) begin
                o_bytes = {16'd0, 2'b10, i_cp[5:0], 3'b110, i_cp[10:6]};
                o_len   = 3'd2;
            end else if (i_cp < 21'h10000) begin
                o_bytes = {8'd0, 2'b10, i_cp[5:0], 2'b10, i_cp[11:6], 4'b1110, i_cp[15:12]};
                o_len   = 3'd3;
            end else begin
                o_bytes = {2'b10, i_cp[5:0], 2'b10, i_cp[11:6], 2'b10, i_cp[17:12],
                           5'b11110, i_cp[20:18]};
                o_len   = 3'd4;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/unicode_escape_to_utf8.sv */
// A deciding character beat passes the input register, then the result register, before its result beat appears.
// Throughput: one character beat per cycle; the input register and the result register
// stall while a held result is not taken, but an empty input register still takes a beat.
// Only the deciding character of a text yields a result; others yield none.
// Reset (synchronous, active low) empties both registers and clears the parser state.
`timescale 1ns / 1ps
`default_nettype none
`include "unicode_escape_to_utf8_assert.svh"
module unicode_escape_to_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [2:0]  o_status,
    output logic      [20:0] o_code_point,
    output logic      [31:0] o_utf8_bytes,
    output logic      [2:0]  o_utf8_length,
    output logic      [3:0]  o_consumed
);

    logic               r_in_valid;
    logic [7:0]         r_ch;
    logic               r_last;
    logic               r_out_valid;
    uce_pkg::t_status   r_status;
    logic [20:0]        r_cp;
    logic [31:0]        r_bytes;
    logic [2:0]         r_len;
    logic [3:0]         r_consumed;
    logic               adv;
    logic               fire;
    uce_pkg::t_step_res res;
    logic [31:0]        enc_bytes;
    logic [2:0]         enc_len;

    assign adv     = !r_out_valid || i_ready;
    assign fire    = r_in_valid && adv;
    assign o_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch   <= i_ch;
            r_last <= i_is_last;
        end
    end

    uce_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_ch      (r_ch),
        .i_is_last (r_last),
        .o_res     (res)
    );

    uce_utf8_enc u_enc (
        .i_ok    (res.status == uce_pkg::ST_OK),
        .i_cp    (res.code_point),
        .o_bytes (enc_bytes),
        .o_len   (enc_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_status   <= res.status;
            r_cp       <= res.code_point;
            r_bytes    <= enc_bytes;
            r_len      <= enc_len;
            r_consumed <= res.consumed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_code_point  = r_cp;
    assign o_utf8_bytes  = r_bytes;
    assign o_utf8_length = r_len;
    assign o_consumed    = r_consumed;

    `UCE_ASSERT_NOW(a_ok_consumed, i_clk, i_rst_n, r_out_valid && r_status == uce_pkg::ST_OK, r_consumed == 4'd6 || r_consumed == 4'd10)
    `UCE_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && r_status != uce_pkg::ST_OK, r_len == 3'd0 && r_cp == 21'd0 && r_bytes == 32'd0)
    `UCE_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, r_out_valid && r_status == uce_pkg::ST_OK, r_cp <= uce_pkg::MAX_CODE_POINT && r_len != 3'd0)
    `UCE_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid && $stable(r_ch) && $stable(r_last))

endmodule
`default_nettype wire

/* verif/unicode_escape_to_utf8_test.sv */
// Testbench for the escape decoder: directed and random texts checked against a predictor.
`timescale 1ns / 1ps
module unicode_escape_to_utf8_test;
    import uce_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [20:0] code_point;
        logic [31:0] bytes;
        logic [2:0]  length;
        logic [3:0]  consumed;
    } t_escape_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_ch;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [20:0] o_code_point;
    logic [31:0] o_utf8_bytes;
    logic [2:0]  o_utf8_length;
    logic [3:0]  o_consumed;

    t_escape_result pending_escapes[$];
    logic [7:0]     text_buf[$];
    int             mismatch_count = 0;
    int             chars_sent = 0;
    int             gap_max = 12;
    int             hold_left = 0;

    logic [3:0]  pos_count;
    logic        lead_backslash;
    logic        long_escape;
    logic        prefix_error;
    logic        digit_error;
    logic [31:0] code_acc;
    logic        answered;

    unicode_escape_to_utf8 u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_ch         (i_ch),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_code_point (o_code_point),
        .o_utf8_bytes (o_utf8_bytes),
        .o_utf8_length(o_utf8_length),
        .o_consumed   (o_consumed)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void clear_decoder();
        pos_count      = '0;
        lead_backslash = 1'b0;
        long_escape    = 1'b0;
        prefix_error   = 1'b0;
        digit_error    = 1'b0;
        code_acc       = '0;
        answered       = 1'b0;
    endfunction

    // Advances the predicted parser by one character and queues the result it decides.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        int             need;
        int             nib;
        logic           have_result;
        t_status        st;
        t_escape_result res;
        logic [20:0]    cp;
        have_result = 1'b0;
        st = ST_OK;
        need = SHORT_DIGITS;
        if (answered) begin
            if (last) clear_decoder();
            return;
        end
        if (pos_count == POS_FIRST) begin
            lead_backslash = (c == CH_BACKSLASH);
            if (last) begin
                have_result = 1'b1;
                st = ST_INCOMPLETE;
            end
        end else if (pos_count == POS_SECOND) begin
            prefix_error = !lead_backslash || (c != CH_LOWER_U && c != CH_UPPER_U);
            long_escape = (c == CH_UPPER_U);
            if (prefix_error) begin
                have_result = 1'b1;
                st = ST_INVALID;
            end else if (last) begin
                have_result = 1'b1;
                st = ST_INCOMPLETE;
            end
        end else begin
            need = long_escape ? LONG_DIGITS : SHORT_DIGITS;
            nib = hex_nibble(c);
            if (nib < 0) begin
                digit_error = 1'b1;
                nib = 0;
            end
            code_acc = {code_acc[27:0], 4'(nib)};
            if (int'(pos_count) == need + 1) begin
                have_result = 1'b1;
                if (digit_error) st = ST_BAD_DIGIT;
                else if (code_acc > 32'(MAX_CODE_POINT)) st = ST_RANGE;
                else st = ST_OK;
            end else if (last) begin
                have_result = 1'b1;
                st = ST_INCOMPLETE;
            end
        end
        pos_count = pos_count + 4'd1;
        if (have_result) begin
            res = '0;
            res.status = st;
            if (st == ST_OK) begin
                cp = code_acc[20:0];
                res.code_point = cp;
                res.consumed = 4'(need + 2);
                if (cp < 21'h80) begin
                    res.bytes = {24'd0, cp[7:0]};
                    res.length = 3'd1;
                end else if (cp < 21'h800) begin
                    res.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
                    res.length = 3'd2;
                end else if (cp < 21'h10000) begin
                    res.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
                    res.length = 3'd3;
                end else begin
                    res.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                                 5'b11110, cp[20:18]};
                    res.length = 3'd4;
                end
            end
            pending_escapes.push_back(res);
            answered = 1'b1;
        end
        if (last) clear_decoder();
    endfunction

    function automatic string describe(input t_escape_result r);
        return $sformatf("status %0d cp %h bytes %h length %0d consumed %0d",
                         r.status, r.code_point, r.bytes, r.length, r.consumed);
    endfunction

    always @(posedge i_clk) begin : check_beat
        t_escape_result got;
        t_escape_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_code_point, o_utf8_bytes, o_utf8_length, o_consumed};
            if (pending_escapes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result beat: %s", describe(got));
                end
            end else begin
                want = pending_escapes.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: expected %s", describe(want));
                        $display("          actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // Receiver: a random stall after every beat, plus long holds requested by a test.
    initial begin : receiver
        bit took;
        int stall_left;
        stall_left = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            took = i_rst_n && o_valid && i_ready;
            @(negedge i_clk);
            if (took) stall_left = $urandom_range(0, gap_max);
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_ch = c;
        i_is_last = last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_char(c, last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    function automatic void load_string(input string s);
        int k;
        text_buf.delete();
        for (k = 0; k < s.len(); k++) text_buf.push_back(s[k]);
    endfunction

    task automatic send_random_texts(input int n_chars);
        int          stop_at;
        int          kind;
        int          need;
        int          cut;
        int          k;
        logic [31:0] value;
        logic [7:0]  junk;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            need = ($urandom_range(0, 1) == 1) ? LONG_DIGITS : SHORT_DIGITS;
            case ($urandom_range(0, 23))
                0:  value = 32'h0;
                1:  value = 32'h7F;
                2:  value = 32'h80;
                3:  value = 32'h7FF;
                4:  value = 32'h800;
                5:  value = 32'hFFFF;
                6:  value = 32'h10000;
                7:  value = 32'h10FFFF;
                8:  value = 32'h110000;
                9:  value = 32'hFFFF_FFFF;
                10: value = $urandom;
                default: value = $urandom_range(0, (need == LONG_DIGITS) ? 32'h10FFFF : 32'hFFFF);
            endcase
            text_buf.delete();
            text_buf.push_back(CH_BACKSLASH);
            text_buf.push_back((need == LONG_DIGITS) ? CH_UPPER_U : CH_LOWER_U);
            for (k = need - 1; k >= 0; k--) text_buf.push_back(hex_char(value[4*k +: 4]));
            if (kind < 55) begin
                junk = 8'h00;
            end else if (kind < 67) begin
                do junk = 8'($urandom); while (hex_nibble(junk) >= 0);
                text_buf[2 + $urandom_range(0, need - 1)] = junk;
            end else if (kind < 77) begin
                cut = $urandom_range(1, need + 1);
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end else if (kind < 87) begin
                if ($urandom_range(0, 1) == 1) text_buf[0] = 8'($urandom);
                else text_buf[1] = 8'($urandom);
            end else begin
                text_buf.delete();
                cut = $urandom_range(1, 12);
                for (k = 0; k < cut; k++) text_buf.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1) text_buf[0] = CH_BACKSLASH;
            end
            if ((kind < 67 || (kind >= 77 && kind < 87)) && $urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, 4);
                for (k = 0; k < cut; k++) text_buf.push_back(8'($urandom));
            end
            send_text();
        end
    endtask

    task automatic test_directed_cases();
        gap_max = 12;
        load_string("\\");
        send_text();
        load_string("\\");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h00);
        send_text();
        load_string("\\u");
        text_buf.push_back(8'hFF);
        send_text();
        load_string("\\U00110000");
        send_text();
        load_string("\\u07fF");
        send_text();
        load_string("\\uD8zA");
        send_text();
    endtask

    task automatic test_random_texts();
        int chunk;
        for (chunk = 0; chunk < 6; chunk++) begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            send_random_texts(200);
        end
    endtask

    task automatic test_full_rate();
        gap_max = 0;
        send_random_texts(200);
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_hold();
        gap_max = 0;
        hold_left = 200;
        send_random_texts(150);
        gap_max = 12;
        send_random_texts(100);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch = 8'h00;
        i_is_last = 1'b0;
        clear_decoder();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_texts();
        test_full_rate();
        test_output_hold();

        i_valid = 1'b0;
        while (pending_escapes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_escapes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/uce_pkg.sv
hdl/uce_step.sv
hdl/uce_utf8_enc.sv
hdl/unicode_escape_to_utf8.sv
verif/unicode_escape_to_utf8_test.sv
